FILE: sv/pdll_pkg.sv
`default_nettype none

package pdll_pkg;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LINK2,
        S_REM2,
        S_REM3,
        S_FIN
    } state_t;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

endpackage

`default_nettype wire

FILE: sv/pooled_doubly_linked_list.sv
`default_nettype none

// Pooled doubly linked list with a free list. One command beat in, one result beat out.
// Link and record state sit in single-port synchronous memories, so a command first
// reads the addressed slot and then writes the links step by step: read goes from S_EXEC
// to S_FIN, append and insert pass through S_LINK2, remove through S_REM2 and S_REM3,
// and a refused append or insert or an out-of-use target goes from S_EXEC to S_FIN. The
// number of writes to the previous-link memory (up to three on remove) sets these steps.
// After reset and after every capacity_in_use write, the link memories are rebuilt by a
// sweep over all POOL_SLOTS slots (64 by default) during which in_stall stays high; capacity
// writes are taken at any time and restart the sweep. The next input beat is taken while
// an earlier result still waits on out_stall. A slot equal to POOL_SLOTS means none.
module pooled_doubly_linked_list #(
    parameter int POOL_SLOTS   = 64,
    parameter int RECORD_WIDTH = 32
) (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     cfg_write_en,
    input  wire  [$clog2(POOL_SLOTS + 1) - 1:0]     capacity_in_use,
    input  wire                                     in_valid,
    output logic                                    in_stall,
    input  wire  [1:0]                              command,
    input  wire  [RECORD_WIDTH - 1:0]               record_word,
    input  wire  [$clog2(POOL_SLOTS + 1) - 1:0]     left_node,
    input  wire  [$clog2(POOL_SLOTS + 1) - 1:0]     right_node,
    input  wire  [$clog2(POOL_SLOTS) - 1:0]         target_node,
    output logic                                    out_valid,
    input  wire                                     out_stall,
    output logic                                    status,
    output logic [$clog2(POOL_SLOTS + 1) - 1:0]     slot_index,
    output logic [RECORD_WIDTH - 1:0]               record_out,
    output logic [$clog2(POOL_SLOTS + 1) - 1:0]     next_slot,
    output logic [$clog2(POOL_SLOTS + 1) - 1:0]     prev_slot,
    output logic [$clog2(POOL_SLOTS + 1) - 1:0]     head_slot,
    output logic [$clog2(POOL_SLOTS + 1) - 1:0]     tail_slot,
    output logic [$clog2(POOL_SLOTS + 1) - 1:0]     list_length,
    output logic                                    is_full
);

    localparam int IW = $clog2(POOL_SLOTS);
    localparam int LW = $clog2(POOL_SLOTS + 1);
    localparam logic [LW-1:0] NIL = LW'(POOL_SLOTS);
    localparam logic [LW-1:0] LAST_SLOT = LW'(POOL_SLOTS - 1);

    typedef logic [LW-1:0] link_t;
    typedef logic [IW-1:0] addr_t;
    typedef logic [RECORD_WIDTH-1:0] rec_t;

    link_t next_mem [POOL_SLOTS];
    link_t prev_mem [POOL_SLOTS];
    rec_t  rec_mem  [POOL_SLOTS];

    pdll_pkg::state_t state_reg, state_next;

    link_t cap_reg;
    link_t head_reg, head_next;
    link_t tail_reg, tail_next;
    link_t fhead_reg, fhead_next;
    link_t count_reg, count_next;
    logic  clr_active_reg;
    link_t clr_idx_reg;

    pdll_pkg::cmd_t cmd_reg;
    rec_t  rec_reg;
    link_t left_reg;
    link_t right_reg;
    addr_t tgt_reg;
    logic  tgt_ok_reg;

    link_t rd_next_reg;
    link_t rd_prev_reg;
    rec_t  rd_rec_reg;

    logic  status_reg, status_next;
    link_t slot_reg, slot_next;
    rec_t  rec_out_reg, rec_out_next;
    link_t nxt_reg, nxt_next;
    link_t prv_reg, prv_next;

    logic  out_valid_reg;
    logic  o_status_reg;
    link_t o_slot_reg;
    rec_t  o_rec_reg;
    link_t o_nxt_reg;
    link_t o_prv_reg;
    link_t o_head_reg;
    link_t o_tail_reg;
    link_t o_count_reg;
    logic  o_full_reg;

    logic  accept;
    logic  out_load;
    pdll_pkg::cmd_t cmd_in;
    logic  in_tgt_ok;
    addr_t rd_addr;
    link_t cap_clamped;
    link_t tgt_link;
    link_t sweep_succ;

    logic  nl_we;
    addr_t nl_addr;
    link_t nl_data;
    logic  pl_we;
    addr_t pl_addr;
    link_t pl_data;
    logic  rs_we;
    addr_t rs_addr;

    assign cmd_in      = pdll_pkg::cmd_t'(command);
    assign in_stall    = (state_reg != pdll_pkg::S_IDLE) || clr_active_reg;
    assign accept      = in_valid && !in_stall;
    assign in_tgt_ok   = LW'(target_node) < cap_reg;
    assign tgt_link    = LW'(tgt_reg);
    assign cap_clamped = (capacity_in_use > NIL) ? NIL : capacity_in_use;
    assign sweep_succ  = clr_idx_reg + LW'(1);

    always_comb
    begin
        if ((cmd_in == pdll_pkg::CMD_APPEND) || (cmd_in == pdll_pkg::CMD_INSERT))
        begin
            rd_addr = (fhead_reg != NIL) ? fhead_reg[IW-1:0] : '0;
        end
        else
        begin
            rd_addr = in_tgt_ok ? target_node : '0;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        fhead_next   = fhead_reg;
        count_next   = count_reg;
        status_next  = status_reg;
        slot_next    = slot_reg;
        rec_out_next = rec_out_reg;
        nxt_next     = nxt_reg;
        prv_next     = prv_reg;
        out_load     = 1'b0;
        nl_we        = 1'b0;
        nl_addr      = '0;
        nl_data      = NIL;
        pl_we        = 1'b0;
        pl_addr      = '0;
        pl_data      = NIL;
        rs_we        = 1'b0;
        rs_addr      = '0;

        if (clr_active_reg)
        begin
            nl_we   = 1'b1;
            nl_addr = clr_idx_reg[IW-1:0];
            nl_data = (sweep_succ < cap_reg) ? sweep_succ : NIL;
            pl_we   = 1'b1;
            pl_addr = clr_idx_reg[IW-1:0];
            pl_data = ((clr_idx_reg != '0) && (clr_idx_reg < cap_reg))
                      ? clr_idx_reg - LW'(1) : NIL;
        end

        case (state_reg)
            pdll_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    status_next  = pdll_pkg::STATUS_DONE;
                    slot_next    = NIL;
                    rec_out_next = '0;
                    nxt_next     = NIL;
                    prv_next     = NIL;
                    state_next   = pdll_pkg::S_EXEC;
                end
            end
            pdll_pkg::S_EXEC:
            begin
                case (cmd_reg)
                    pdll_pkg::CMD_APPEND,
                    pdll_pkg::CMD_INSERT:
                    begin
                        if (fhead_reg == NIL)
                        begin
                            status_next = pdll_pkg::STATUS_REFUSED;
                            state_next  = pdll_pkg::S_FIN;
                        end
                        else
                        begin
                            slot_next  = fhead_reg;
                            fhead_next = rd_next_reg;
                            rs_we      = 1'b1;
                            rs_addr    = fhead_reg[IW-1:0];
                            if (left_reg != NIL)
                            begin
                                nl_we   = 1'b1;
                                nl_addr = left_reg[IW-1:0];
                                nl_data = fhead_reg;
                            end
                            pl_we   = 1'b1;
                            pl_addr = fhead_reg[IW-1:0];
                            pl_data = left_reg;
                            if (count_reg != NIL)
                            begin
                                count_next = count_reg + LW'(1);
                            end
                            if (left_reg == NIL)
                            begin
                                head_next = fhead_reg;
                            end
                            if (right_reg == NIL)
                            begin
                                tail_next = fhead_reg;
                            end
                            state_next = pdll_pkg::S_LINK2;
                        end
                    end
                    pdll_pkg::CMD_REMOVE:
                    begin
                        slot_next = tgt_link;
                        if (tgt_ok_reg)
                        begin
                            if (tgt_link == head_reg)
                            begin
                                head_next = rd_next_reg;
                            end
                            if (tgt_link == tail_reg)
                            begin
                                tail_next = rd_prev_reg;
                            end
                            if (rd_prev_reg != NIL)
                            begin
                                nl_we   = 1'b1;
                                nl_addr = rd_prev_reg[IW-1:0];
                                nl_data = rd_next_reg;
                            end
                            if (rd_next_reg != NIL)
                            begin
                                pl_we   = 1'b1;
                                pl_addr = rd_next_reg[IW-1:0];
                                pl_data = rd_prev_reg;
                            end
                            state_next = pdll_pkg::S_REM2;
                        end
                        else
                        begin
                            state_next = pdll_pkg::S_FIN;
                        end
                    end
                    default:
                    begin
                        slot_next = tgt_link;
                        if (tgt_ok_reg)
                        begin
                            rec_out_next = rd_rec_reg;
                            nxt_next     = rd_next_reg;
                            prv_next     = rd_prev_reg;
                        end
                        state_next = pdll_pkg::S_FIN;
                    end
                endcase
            end
            pdll_pkg::S_LINK2:
            begin
                nl_we   = 1'b1;
                nl_addr = slot_reg[IW-1:0];
                nl_data = right_reg;
                if (right_reg != NIL)
                begin
                    pl_we   = 1'b1;
                    pl_addr = right_reg[IW-1:0];
                    pl_data = slot_reg;
                end
                state_next = pdll_pkg::S_FIN;
            end
            pdll_pkg::S_REM2:
            begin
                nl_we      = 1'b1;
                nl_addr    = tgt_reg;
                nl_data    = fhead_reg;
                pl_we      = 1'b1;
                pl_addr    = tgt_reg;
                pl_data    = NIL;
                state_next = pdll_pkg::S_REM3;
            end
            pdll_pkg::S_REM3:
            begin
                if (fhead_reg != NIL)
                begin
                    pl_we   = 1'b1;
                    pl_addr = fhead_reg[IW-1:0];
                    pl_data = tgt_link;
                end
                fhead_next = tgt_link;
                if (count_reg != '0)
                begin
                    count_next = count_reg - LW'(1);
                end
                state_next = pdll_pkg::S_FIN;
            end
            pdll_pkg::S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = pdll_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pdll_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (nl_we)
        begin
            next_mem[nl_addr] <= nl_data;
        end
        if (accept)
        begin
            rd_next_reg <= next_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pl_we)
        begin
            prev_mem[pl_addr] <= pl_data;
        end
        if (accept)
        begin
            rd_prev_reg <= prev_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rs_we)
        begin
            rec_mem[rs_addr] <= rec_reg;
        end
        if (accept)
        begin
            rd_rec_reg <= rec_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pdll_pkg::S_IDLE;
            cap_reg        <= NIL;
            head_reg       <= NIL;
            tail_reg       <= NIL;
            fhead_reg      <= '0;
            count_reg      <= '0;
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
            begin
                cap_reg        <= cap_clamped;
                head_reg       <= NIL;
                tail_reg       <= NIL;
                fhead_reg      <= (cap_clamped != '0) ? '0 : NIL;
                count_reg      <= '0;
                clr_active_reg <= 1'b1;
                clr_idx_reg    <= '0;
            end
            else
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                fhead_reg <= fhead_next;
                count_reg <= count_next;
                if (clr_active_reg)
                begin
                    clr_idx_reg <= sweep_succ;
                    if (clr_idx_reg == LAST_SLOT)
                    begin
                        clr_active_reg <= 1'b0;
                    end
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        slot_reg    <= slot_next;
        rec_out_reg <= rec_out_next;
        nxt_reg     <= nxt_next;
        prv_reg     <= prv_next;
        if (accept)
        begin
            cmd_reg    <= cmd_in;
            rec_reg    <= record_word;
            tgt_reg    <= target_node;
            tgt_ok_reg <= in_tgt_ok;
            if (cmd_in == pdll_pkg::CMD_APPEND)
            begin
                left_reg  <= tail_reg;
                right_reg <= NIL;
            end
            else
            begin
                left_reg  <= (left_node < cap_reg) ? left_node : NIL;
                right_reg <= (right_node < cap_reg) ? right_node : NIL;
            end
        end
        if (out_load)
        begin
            o_status_reg <= status_reg;
            o_slot_reg   <= slot_reg;
            o_rec_reg    <= rec_out_reg;
            o_nxt_reg    <= nxt_reg;
            o_prv_reg    <= prv_reg;
            o_head_reg   <= head_reg;
            o_tail_reg   <= tail_reg;
            o_count_reg  <= count_reg;
            o_full_reg   <= (fhead_reg == NIL) && (cap_reg != '0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = o_status_reg;
    assign slot_index  = o_slot_reg;
    assign record_out  = o_rec_reg;
    assign next_slot   = o_nxt_reg;
    assign prev_slot   = o_prv_reg;
    assign head_slot   = o_head_reg;
    assign tail_slot   = o_tail_reg;
    assign list_length = o_count_reg;
    assign is_full     = o_full_reg;

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == pdll_pkg::S_EXEC))
        else $error("accepted beat did not enter execution");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == pdll_pkg::S_IDLE) && !clr_active_reg) |-> !(nl_we || pl_we || rs_we))
        else $error("memory write while idle");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == pdll_pkg::S_FIN))
        else $error("result beat raised outside finish");

    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= NIL) && (fhead_reg <= NIL) && (cap_reg <= NIL))
        else $error("count, free head or capacity out of range");

endmodule

`default_nettype wire
